// ===== sv/channel_alarm_event_classifier_macros.svh =====
// Assertion helpers for the alarm event classifier.
`ifndef CHANNEL_ALARM_EVENT_CLASSIFIER_MACROS_SVH
`define CHANNEL_ALARM_EVENT_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CAEC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CAEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/caec_pkg.sv =====
package caec_pkg;

  localparam int CHANNEL_COUNT = 8;
  localparam int SLOT_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int CFG_IDX_W = 4;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_CODE       = 4'd0,
    REG_ALARM_DEVIATION   = 4'd1,
    REG_GUARD_DEVIATION   = 4'd2,
    REG_LONG_ALARM_FRAMES = 4'd3
  } cfg_reg_t;

  localparam logic [15:0] CENTRE_CODE_RST       = 16'd32768;
  localparam logic [15:0] ALARM_DEVIATION_RST   = 16'd1638;
  localparam logic [15:0] GUARD_DEVIATION_RST   = 16'd328;
  localparam logic [7:0]  LONG_ALARM_FRAMES_RST = 8'd60;

  // event kinds
  localparam logic [1:0] KIND_GUARD = 2'd0;
  localparam logic [1:0] KIND_ALARM = 2'd1;
  localparam logic [1:0] KIND_LONG  = 2'd2;

  localparam logic [7:0] RUN_MAX = 8'hFF;

  typedef struct packed {
    logic [15:0] sample;
    logic [2:0]  channel;
    logic        frame_first;
    logic        frame_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [2:0]         event_channel;
    logic signed [15:0] level;
    logic [31:0]        event_index;
  } out_item_t;

  // write port of the run count store
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [7:0]        data;
  } run_wr_t;

endpackage

// ===== sv/caec_run_store.sv =====
module caec_run_store (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [caec_pkg::SLOT_W-1:0] rd_addr,
  input  caec_pkg::run_wr_t wr,
  output logic [7:0]        rd_data
);
  import caec_pkg::*;

  logic [7:0]               mem [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] valid_r;
  logic [7:0]               mem_q_r;
  logic                     vld_q_r;
  logic                     byp_hit_r;
  logic [7:0]               byp_data_r;

  // per-entry valid bits stand in for clearing the counts at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr];
      vld_q_r    <= valid_r[rd_addr];
      // write landing on the same edge as the read: forward it
      byp_hit_r  <= wr.en && (wr.addr == rd_addr);
      byp_data_r <= wr.data;
    end
  end

  assign rd_data = byp_hit_r ? byp_data_r : (vld_q_r ? mem_q_r : 8'd0);

endmodule

// ===== sv/channel_alarm_event_classifier.sv =====
// Channel     Ports                                  Direction  Moves
// input       in_valid, in_stall, in_item            in         one sample item
// result      out_valid, out_stall, out_item         out        one event item
// config      cfg_valid, cfg_ready, cfg_index/data   in         one register write
//
// One item per cycle while in_stall is low; the run count is read as an item is accepted
// into the classify stage; an event it raises is then registered into the output register.
// A write-to-read bypass on the run count store keeps back-to-back frames on one
// channel exact.
// Synchronous reset restores the registers; valid bits make all run counts read zero.
// in_stall rises only when the classify stage holds an event behind a full, stalled output.

`include "channel_alarm_event_classifier_macros.svh"

module channel_alarm_event_classifier (
  input  logic                clk,
  input  logic                rst_n,
  // sample items
  input  logic                in_valid,
  output logic                in_stall,
  input  caec_pkg::in_item_t  in_item,
  // event items
  output logic                out_valid,
  input  logic                out_stall,
  output caec_pkg::out_item_t out_item,
  // register writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [caec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]         cfg_data
);
  import caec_pkg::*;

  // ---------------- configuration registers ----------------
  logic [15:0] centre_r;
  logic [15:0] alarm_dev_r;
  logic [15:0] guard_dev_r;
  logic [7:0]  long_frames_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r      <= CENTRE_CODE_RST;
      alarm_dev_r   <= ALARM_DEVIATION_RST;
      guard_dev_r   <= GUARD_DEVIATION_RST;
      long_frames_r <= LONG_ALARM_FRAMES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTRE_CODE:       centre_r      <= cfg_data;
        REG_ALARM_DEVIATION:   alarm_dev_r   <= cfg_data;
        REG_GUARD_DEVIATION:   guard_dev_r   <= cfg_data;
        REG_LONG_ALARM_FRAMES: long_frames_r <= cfg_data[7:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- input stage: deviation and magnitude ----------------
  logic                in_acc;
  logic [16:0]         diff0;
  logic signed [15:0]  dev0;
  logic [16:0]         mag0;
  logic [SLOT_W-1:0]   slot0;

  assign in_acc = in_valid && !in_stall;
  assign diff0  = {1'b0, in_item.sample} - {1'b0, centre_r};

  // saturate the 17 bit difference into 16 bit signed
  always_comb begin
    if (diff0[16] != diff0[15]) begin
      dev0 = diff0[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      dev0 = diff0[15:0];
    end
  end

  // 17 bits so the most negative deviation gives a magnitude of 32768
  assign mag0  = dev0[15] ? (17'd0 - {1'b1, dev0}) : {1'b0, dev0};
  assign slot0 = SLOT_W'(in_item.channel % CHANNEL_COUNT);

  // ---------------- run count store ----------------
  run_wr_t    run_wr;
  logic [7:0] runs;

  caec_run_store u_runs (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (slot0),
    .wr      (run_wr),
    .rd_data (runs)
  );

  // ---------------- classify stage ----------------
  logic               s1_v_r;
  logic signed [15:0] s1_dev_r;
  logic [16:0]        s1_mag_r;
  logic [2:0]         s1_ch_r;
  logic [SLOT_W-1:0]  s1_slot_r;
  logic               s1_first_r;
  logic               s1_last_r;

  // frame state, shared across channels as frames arrive one after another
  logic signed [15:0] peak_r, peak_nxt;
  logic [16:0]        peak_mag_r, peak_mag_nxt;
  logic               alarmed_r, alarmed_nxt;
  logic [31:0]        total_r;

  logic               out_v_r;
  out_item_t          out_item_r;

  logic               out_free;
  logic               s1_go;
  logic               emit;
  logic [1:0]         kind;
  logic signed [15:0] level;
  run_wr_t            s1_wr;
  logic               alarm_hit;
  logic               mid_alarm;
  logic [7:0]         runs_inc;
  logic               eff_alarmed;
  logic signed [15:0] eff_peak;
  logic [16:0]        eff_pmag;

  assign out_free = !out_v_r || !out_stall;

  always_comb begin
    emit         = 1'b0;
    kind         = KIND_GUARD;
    level        = s1_dev_r;
    s1_wr        = '0;
    mid_alarm    = 1'b0;
    peak_nxt     = peak_r;
    peak_mag_nxt = peak_mag_r;
    alarmed_nxt  = alarmed_r;

    alarm_hit = s1_mag_r >= {1'b0, alarm_dev_r};
    runs_inc  = (runs == RUN_MAX) ? runs : runs + 8'd1;

    // a first sample reseeds the frame before any end-of-frame step
    eff_alarmed = s1_first_r ? 1'b0 : alarmed_r;
    eff_peak    = s1_first_r ? s1_dev_r : peak_r;
    eff_pmag    = s1_first_r ? s1_mag_r : peak_mag_r;

    if (s1_first_r) begin
      peak_nxt     = s1_dev_r;
      peak_mag_nxt = s1_mag_r;
      alarmed_nxt  = 1'b0;
    end

    if (!s1_first_r && !s1_last_r && !alarmed_r) begin
      if (alarm_hit) begin
        mid_alarm   = 1'b1;
        alarmed_nxt = 1'b1;
        s1_wr       = '{en: 1'b1, addr: s1_slot_r, data: runs_inc};
        emit        = 1'b1;
        kind        = (runs_inc < long_frames_r) ? KIND_ALARM : KIND_LONG;
      end else if (s1_mag_r > peak_mag_r) begin
        peak_nxt     = s1_dev_r;
        peak_mag_nxt = s1_mag_r;
      end
    end

    // end of a quiet frame: clear the run, maybe report the peak
    if (s1_last_r && !eff_alarmed) begin
      s1_wr = '{en: 1'b1, addr: s1_slot_r, data: 8'd0};
      if (eff_pmag >= {1'b0, guard_dev_r}) begin
        emit  = 1'b1;
        level = eff_peak;
        if (eff_pmag < {1'b0, alarm_dev_r}) begin
          kind = KIND_GUARD;
        end else begin
          kind = (long_frames_r != 8'd0) ? KIND_ALARM : KIND_LONG;
        end
      end
    end
  end

  assign s1_go    = s1_v_r && (!emit || out_free);
  assign in_stall = s1_v_r && !s1_go;

  always_comb begin
    run_wr    = s1_wr;
    run_wr.en = s1_wr.en && s1_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      peak_r     <= '0;
      peak_mag_r <= '0;
      alarmed_r  <= 1'b0;
      total_r    <= '0;
      out_v_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        peak_r     <= peak_nxt;
        peak_mag_r <= peak_mag_nxt;
        alarmed_r  <= alarmed_nxt;
      end
      if (s1_go && emit) begin
        total_r <= total_r + 32'd1;
        out_v_r <= 1'b1;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_dev_r   <= dev0;
      s1_mag_r   <= mag0;
      s1_ch_r    <= in_item.channel;
      s1_slot_r  <= slot0;
      s1_first_r <= in_item.frame_first;
      s1_last_r  <= in_item.frame_last;
    end
    if (s1_go && emit) begin
      out_item_r.event_kind    <= kind;
      out_item_r.event_channel <= s1_ch_r;
      out_item_r.level         <= level;
      out_item_r.event_index   <= total_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

  // ---------------- checks ----------------
  `CAEC_ASSERT_IMPLIES(a_stall_needs_item, clk, rst_n, in_stall, s1_v_r && emit && !out_free, "input stalled without a blocked event")
  `CAEC_ASSERT_NEXT(a_index_counts, clk, rst_n, s1_go && emit, total_r == $past(total_r) + 32'd1, "event number did not advance")
  `CAEC_ASSERT_IMPLIES(a_alarm_writes_run, clk, rst_n, s1_go && mid_alarm, run_wr.en && (run_wr.data != 8'd0), "alarm did not bump the run count")

endmodule

// ===== sim/tb_channel_alarm_event_classifier.sv =====
module tb_channel_alarm_event_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import caec_pkg::*;

  // Generous bound: every item waiting out the longest input gap and the longest
  // output stall, plus the settle pauses between register phases.
  localparam int CYCLE_LIMIT = 400000;

  // Predictor plus in-order store of the events still owed by the block.
  class event_scoreboard;
    localparam int REPORT_CAP = 100;

    logic [15:0]        centre;
    logic [15:0]        alarm_dev;
    logic [15:0]        guard_dev;
    logic [7:0]         long_frames;
    logic [7:0]         runs [CHANNEL_COUNT];
    logic signed [15:0] peak;
    bit                 alarmed;
    logic [31:0]        next_index;
    out_item_t          owed_events[$];
    int                 errors;

    function new();
      centre      = CENTRE_CODE_RST;
      alarm_dev   = ALARM_DEVIATION_RST;
      guard_dev   = GUARD_DEVIATION_RST;
      long_frames = LONG_ALARM_FRAMES_RST;
      foreach (runs[i]) runs[i] = '0;
      peak       = '0;
      alarmed    = 1'b0;
      next_index = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        REG_CENTRE_CODE:       centre      = val;
        REG_ALARM_DEVIATION:   alarm_dev   = val;
        REG_GUARD_DEVIATION:   guard_dev   = val;
        REG_LONG_ALARM_FRAMES: long_frames = val[7:0];
        default: ;
      endcase
    endfunction

    // sample minus centre, clipped to the signed 16-bit range
    function logic signed [15:0] deviation(logic [15:0] s);
      int d;
      d = int'(s) - int'(centre);
      if (d > 32767) d = 32767;
      if (d < -32768) d = -32768;
      return 16'(d);
    endfunction

    function int mag(logic signed [15:0] v);
      return (v < 0) ? -int'(v) : int'(v);
    endfunction

    function logic [1:0] kind_of(int m, logic [7:0] run_count);
      if (m < int'(alarm_dev)) return KIND_GUARD;
      return (run_count < long_frames) ? KIND_ALARM : KIND_LONG;
    endfunction

    function void queue_event(logic [1:0] k, logic [2:0] ch, logic signed [15:0] lvl);
      out_item_t ev;
      ev.event_kind    = k;
      ev.event_channel = ch;
      ev.level         = lvl;
      ev.event_index   = next_index;
      next_index       = next_index + 32'd1;
      owed_events.insert(owed_events.size(), ev);
    endfunction

    function void note_sample(in_item_t it);
      logic signed [15:0] d;
      int slot;
      d    = deviation(it.sample);
      slot = int'(it.channel) % CHANNEL_COUNT;
      if (it.frame_first) begin
        peak    = d;
        alarmed = 1'b0;
      end else if (!it.frame_last) begin
        if (alarmed) return;
        if (mag(d) >= int'(alarm_dev)) begin
          alarmed = 1'b1;
          if (runs[slot] != RUN_MAX) runs[slot] = runs[slot] + 8'd1;
          queue_event(kind_of(mag(d), runs[slot]), it.channel, d);
          return;
        end
        if (mag(d) > mag(peak)) peak = d;
        return;
      end
      // end of frame: a clean frame clears the run, a big peak raises an event
      if (it.frame_last && !alarmed) begin
        runs[slot] = '0;
        if (mag(peak) >= int'(guard_dev))
          queue_event(kind_of(mag(peak), 8'd0), it.channel, peak);
      end
    endfunction

    task report(string what);
      if (errors < REPORT_CAP) $display("%0t ERROR %s", $time, what);
      errors++;
    endtask

    task check_event(out_item_t got);
      out_item_t want;
      string     diffs;
      if (owed_events.size() == 0) begin
        report($sformatf("unexpected event kind %0d ch %0d level %0d index %0d",
                         got.event_kind, got.event_channel, got.level, got.event_index));
        return;
      end
      want  = owed_events.pop_front();
      diffs = "";
      if (got.event_kind !== want.event_kind)
        diffs = {diffs, $sformatf(" kind %0d/%0d", got.event_kind, want.event_kind)};
      if (got.event_channel !== want.event_channel)
        diffs = {diffs, $sformatf(" ch %0d/%0d", got.event_channel, want.event_channel)};
      if (got.level !== want.level)
        diffs = {diffs, $sformatf(" level %0d/%0d", got.level, want.level)};
      if (got.event_index !== want.event_index)
        diffs = {diffs, $sformatf(" index %0d/%0d", got.event_index, want.event_index)};
      if (diffs != "")
        report($sformatf("event %0d got/expected:%s", want.event_index, diffs));
    endtask

    task check_drained();
      out_item_t want;
      while (owed_events.size() != 0) begin
        want = owed_events.pop_front();
        report($sformatf("event %0d never arrived (kind %0d ch %0d level %0d)",
                         want.event_index, want.event_kind, want.event_channel, want.level));
      end
    endtask

    function int pending();
      return owed_events.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_item;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_item;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [15:0]            cfg_data;

  event_scoreboard sb;

  // Idle pressure knobs; calm switches all idling off for the final stretch.
  bit calm      = 1'b0;
  int gap_pct   = 0;
  int stall_pct = 0;
  int sent      = 0;
  int cycles    = 0;

  channel_alarm_event_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Observe all three handshakes at the rising edge. The result is checked
  // before this edge's sample is noted: an event never comes from the item
  // accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_event(out_item);
      if (in_valid && !in_stall)   sb.note_sample(in_item);
      if (cfg_valid && cfg_ready)  sb.set_reg(cfg_index, cfg_data);
    end
  end

  function automatic int pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 10;
      default: return 40;
    endcase
  endfunction

  // Receiver stall: bursts of random length at a density of 0, 10 or 40 percent,
  // re-drawn periodically so that some stretches see no stall at all.
  initial begin
    int left;
    int age;
    left      = 0;
    age       = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (age == 0) begin
        stall_pct = pick_pct();
        age = 64;
      end
      age--;
      if (left == 0 && !calm && $urandom_range(99) < stall_pct)
        left = $urandom_range(11, 1);
      out_stall <= (left != 0);
      if (left != 0) left--;
    end
  end

  // One sample item; optional idle burst first, then hold until accepted.
  task automatic send_sample(logic [15:0] s, logic [2:0] ch, bit first, bit last);
    in_item_t it;
    int gap;
    it.sample      = s;
    it.channel     = ch;
    it.frame_first = first;
    it.frame_last  = last;
    gap = (!calm && $urandom_range(99) < gap_pct) ? $urandom_range(11, 1) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every owed event, then let items still in the pipe
  // that produce nothing drain.
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(int centre, int alarm, int guard, int long_run);
    write_reg(REG_CENTRE_CODE, 16'(centre));
    write_reg(REG_ALARM_DEVIATION, 16'(alarm));
    write_reg(REG_GUARD_DEVIATION, 16'(guard));
    write_reg(REG_LONG_ALARM_FRAMES, 16'(long_run));
  endtask

  // Sample placed relative to the current thresholds:
  // 0 = quiet, 1 = between guard and alarm, 2 = alarm level. Some are raw noise.
  function automatic logic [15:0] pick_sample(int cls);
    int lo;
    int hi;
    int m;
    int v;
    if ($urandom_range(9) == 0) return 16'($urandom);
    case (cls)
      0: begin
        lo = 0;
        hi = int'(sb.guard_dev);
      end
      1: begin
        lo = int'(sb.guard_dev);
        hi = int'(sb.alarm_dev);
      end
      default: begin
        lo = int'(sb.alarm_dev);
        hi = lo + 3000;
      end
    endcase
    if (hi < lo) hi = lo;
    m = $urandom_range(hi, lo);
    v = $urandom_range(1) ? int'(sb.centre) + m : int'(sb.centre) - m;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // Mostly well-formed frames on random channels, with some stray items
  // carrying arbitrary markers mixed in.
  task automatic random_frames(int n_items, int alarm_pct);
    int goal;
    int len;
    int r;
    logic [2:0] ch;
    goal = sent + n_items;
    while (sent < goal) begin
      if ($urandom_range(99) < 10) gap_pct = pick_pct();
      if ($urandom_range(99) < 8) begin
        send_sample(16'($urandom), 3'($urandom), 1'($urandom), 1'($urandom));
        continue;
      end
      ch  = 3'($urandom);
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(99);
        send_sample(pick_sample((r < alarm_pct) ? 2 : ((r < alarm_pct + 35) ? 1 : 0)),
                    ch, k == 0, k == len - 1);
      end
    end
  endtask

  // Back-to-back alarm frames on one channel, long enough to pass the run
  // limit and saturate the run count. Frames have no last marker, so the run
  // is never cleared; other channels cut in now and then.
  task automatic alarm_streak(logic [2:0] ch, int frames);
    logic [2:0] other;
    for (int f = 0; f < frames; f++) begin
      if ($urandom_range(99) < 15) begin
        other = ch + 3'($urandom_range(7, 1));
        send_sample(pick_sample(0), other, 1'b1, 1'b0);
        send_sample(pick_sample(2), other, 1'b0, 1'b1);
      end
      if ($urandom_range(99) < 10) gap_pct = pick_pct();
      send_sample(pick_sample(0), ch, 1'b1, 1'b0);
      send_sample(pick_sample(2), ch, 1'b0, 1'b0);
    end
  endtask

  initial begin
    int a;
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed frames at reset thresholds (alarm 1638, guard 328, long 60).
    // alarm mid-frame, later middles ignored, last after alarm does nothing
    send_sample(16'd32768, 3'd0, 1'b1, 1'b0);
    send_sample(16'd32868, 3'd0, 1'b0, 1'b0);
    send_sample(16'd30768, 3'd0, 1'b0, 1'b0);
    send_sample(16'd65535, 3'd0, 1'b0, 1'b0);
    send_sample(16'd0,     3'd0, 1'b0, 1'b1);
    // clean frame whose positive peak crosses guard
    send_sample(16'd32768, 3'd1, 1'b1, 1'b0);
    send_sample(16'd33268, 3'd1, 1'b0, 1'b0);
    send_sample(16'd32368, 3'd1, 1'b0, 1'b0);
    send_sample(16'd32768, 3'd1, 1'b0, 1'b1);
    // single-sample frame: large seed goes straight to the end-of-frame step
    send_sample(16'd34768, 3'd2, 1'b1, 1'b1);
    // quiet frame, no event
    send_sample(16'd32778, 3'd3, 1'b1, 1'b0);
    send_sample(16'd32768, 3'd3, 1'b0, 1'b1);
    // no first marker: continues the open frame; repeated last repeats the event
    send_sample(16'd33168, 3'd4, 1'b0, 1'b0);
    send_sample(16'd32768, 3'd4, 1'b0, 1'b1);
    send_sample(16'd32768, 3'd4, 1'b0, 1'b1);
    // code extremes: most negative seed, then full-scale alarm
    send_sample(16'd0,     3'd7, 1'b1, 1'b0);
    send_sample(16'd65535, 3'd7, 1'b0, 1'b0);
    send_sample(16'd0,     3'd7, 1'b0, 1'b1);
    // negative peak reaching guard
    send_sample(16'd32768, 3'd6, 1'b1, 1'b0);
    send_sample(16'd32368, 3'd6, 1'b0, 1'b0);
    send_sample(16'd32768, 3'd6, 1'b0, 1'b1);
    send_sample(16'd32768, 3'd5, 1'b1, 1'b1);

    random_frames(330, 12);

    // centre at the bottom: positive deviations clip; every frame end is a guard
    // event, alarms are out of reach, long after one frame
    wait_idle();
    configure(0, 65535, 0, 1);
    random_frames(200, 10);

    // centre at the top, zero alarm threshold: every middle alarms; run count
    // climbs to the 255 limit and saturates
    wait_idle();
    configure(65535, 0, 65535, 255);
    alarm_streak(3'($urandom), 265);

    // random thresholds with a short long-alarm limit
    wait_idle();
    a = $urandom_range(3000, 50);
    configure($urandom_range(65535), a, $urandom_range(a), $urandom_range(6, 1));
    random_frames(300, 15);

    wait_idle();
    a = $urandom_range(2500, 300);
    configure(32768, a, $urandom_range(a), 3);
    random_frames(150, 12);
    // tail at full rate on both sides
    calm = 1'b1;
    random_frames(150, 12);

    wait_idle();
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== channel_alarm_event_classifier.f =====
+incdir+sv
sv/caec_pkg.sv
sv/caec_run_store.sv
sv/channel_alarm_event_classifier.sv
sim/tb_channel_alarm_event_classifier.sv
